[rtl/i2crm_pkg.sv]
package i2crm_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [7:0]  byte_count;
    logic [7:0]  wr_data;
    logic        sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       wr_take;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
  } out_word_t;

  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_REG_WR = 2'd2;
  localparam logic [1:0] REQ_REG_RD = 2'd3;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_WIDE    = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd250;

  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_START1   = 16'h0002,
    PH_DEV      = 16'h0004,
    PH_DEV_ACK  = 16'h0008,
    PH_RHI      = 16'h0010,
    PH_RHI_ACK  = 16'h0020,
    PH_RLO      = 16'h0040,
    PH_RLO_ACK  = 16'h0080,
    PH_DATA     = 16'h0100,
    PH_DATA_ACK = 16'h0200,
    PH_STOP_MID = 16'h0400,
    PH_START2   = 16'h0800,
    PH_DEVR     = 16'h1000,
    PH_DEVR_ACK = 16'h2000,
    PH_READ     = 16'h4000,
    PH_STOP     = 16'h8000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  step;
    logic [2:0]  bits;
    logic [7:0]  shift;
    logic [7:0]  left;
    logic [15:0] wait_cnt;
    logic [7:0]  dev;
    logic [15:0] regad;
    logic [1:0]  kind;
    logic        err;
  } seq_state_t;

endpackage

[rtl/i2crm_if.sv]
interface i2crm_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/i2crm_seq.sv]
module i2crm_seq (
  input  i2crm_pkg::seq_state_t st,
  input  i2crm_pkg::in_word_t   iw,
  input  logic [15:0]           timeout_limit,
  input  logic                  wide,
  output i2crm_pkg::seq_state_t st_next,
  output i2crm_pkg::out_word_t  ow
);
  import i2crm_pkg::*;

  seq_state_t s;
  logic [1:0] sp;
  logic [7:0] ld;

  function automatic seq_state_t enter_ph(seq_state_t x, phase_t p);
    seq_state_t r;
    r = x;
    r.phase = p;
    r.step = 2'd0;
    r.bits = 3'd0;
    r.wait_cnt = 16'd0;
    return r;
  endfunction

  always_comb begin
    s = st;
    ow = '0;
    sp = 2'd0;
    ld = 8'd0;
    if (st.phase == PH_IDLE && iw.req_type != REQ_NONE) begin
      s.kind = iw.req_type;
      s.dev = iw.dev_addr;
      s.regad = iw.reg_addr;
      s.left = iw.byte_count;
      s.err = 1'b0;
      s = enter_ph(s, PH_START1);
    end
    ow.busy_res = 1'b1;
    unique case (s.phase)
      PH_START1, PH_START2: begin
        ow.scl = (s.step != 2'd3);
        ow.sda_out = (s.step < 2'd2);
        ow.sda_drive = 1'b1;
        if (s.step == 2'd3) s = enter_ph(s, (s.phase == PH_START1) ? PH_DEV : PH_DEVR);
        else s.step = s.step + 2'd1;
      end
      PH_DEV, PH_RHI, PH_RLO, PH_DATA, PH_DEVR: begin
        ow.sda_drive = 1'b1;
        if (s.step == 2'd3) begin
          ow.sda_out = 1'b1;
          if (s.bits >= 3'd1) begin
            unique case (s.phase)
              PH_DEV:  s = enter_ph(s, PH_DEV_ACK);
              PH_RHI:  s = enter_ph(s, PH_RHI_ACK);
              PH_RLO:  s = enter_ph(s, PH_RLO_ACK);
              PH_DATA: s = enter_ph(s, PH_DATA_ACK);
              default: s = enter_ph(s, PH_DEVR_ACK);
            endcase
          end else s.bits = s.bits + 3'd1;
        end else begin
          if (s.step == 2'd0 && s.bits == 3'd0) begin
            unique case (s.phase)
              PH_DEV:  s.shift = s.dev;
              PH_DEVR: s.shift = s.dev + 8'd1;
              PH_RHI:  s.shift = s.regad[15:8];
              PH_RLO:  s.shift = s.regad[7:0];
              default: begin
                s.shift = iw.wr_data;
                ow.wr_take = 1'b1;
              end
            endcase
          end
          ow.scl = (s.step == 2'd1);
          ow.sda_out = s.shift[3'd7 - s.bits];
          if (s.step == 2'd2) begin
            s.step = 2'd0;
            if (s.bits == 3'd7) begin
              s.step = 2'd3;
              s.bits = 3'd0;
            end else s.bits = s.bits + 3'd1;
          end else s.step = s.step + 2'd1;
        end
      end
      PH_DEV_ACK, PH_RHI_ACK, PH_RLO_ACK, PH_DATA_ACK, PH_DEVR_ACK: begin
        if (s.step == 2'd0) s.step = 2'd1;
        else begin
          ow.scl = 1'b1;
          if (s.step == 2'd1) s.step = 2'd2;
          else if (!iw.sda_in) begin
            unique case (s.phase)
              PH_DEV_ACK:
                if (s.kind == REQ_WRITE) s = enter_ph(s, (s.left != 8'd0) ? PH_DATA : PH_STOP);
                else s = enter_ph(s, wide ? PH_RHI : PH_RLO);
              PH_RHI_ACK: s = enter_ph(s, PH_RLO);
              PH_RLO_ACK:
                if (s.kind == REQ_REG_RD) s = enter_ph(s, PH_STOP_MID);
                else s = enter_ph(s, (s.left != 8'd0) ? PH_DATA : PH_STOP);
              PH_DATA_ACK: begin
                s.left = s.left - 8'd1;
                s = enter_ph(s, (s.left != 8'd0) ? PH_DATA : PH_STOP);
              end
              default: s = enter_ph(s, (s.left != 8'd0) ? PH_READ : PH_STOP);
            endcase
          end else if (s.wait_cnt >= timeout_limit) begin
            s.err = 1'b1;
            s = enter_ph(s, PH_STOP);
          end else s.wait_cnt = s.wait_cnt + 16'd1;
        end
      end
      PH_READ: begin
        if (s.step == 2'd3) begin
          ow.sda_drive = 1'b1;
          ow.sda_out = !(s.left > 8'd1);
          ow.scl = (s.bits == 3'd1);
          if (s.bits >= 3'd2) begin
            ld = s.left - 8'd1;
            s.left = ld;
            s = enter_ph(s, (ld != 8'd0) ? PH_READ : PH_STOP);
          end else s.bits = s.bits + 3'd1;
        end else if (s.step == 2'd0) s.step = 2'd1;
        else begin
          ow.scl = 1'b1;
          s.shift = {s.shift[6:0], iw.sda_in};
          if (s.bits == 3'd7) begin
            ow.rd_data = s.shift;
            ow.rd_valid = 1'b1;
            s.step = 2'd3;
            s.bits = 3'd0;
          end else begin
            s.bits = s.bits + 3'd1;
            s.step = 2'd0;
          end
        end
      end
      PH_STOP_MID, PH_STOP: begin
        sp = (s.step > 2'd2) ? 2'd2 : s.step;
        ow.scl = (sp != 2'd0);
        ow.sda_out = (sp == 2'd2);
        ow.sda_drive = 1'b1;
        if (sp == 2'd2) begin
          if (s.phase == PH_STOP) begin
            ow.done_res = 1'b1;
            ow.nack_error = s.err;
            s = enter_ph(s, PH_IDLE);
          end else s = enter_ph(s, PH_START2);
        end else s.step = s.step + 2'd1;
      end
      default: begin
        s = enter_ph(s, PH_IDLE);
        ow.scl = 1'b1;
        ow.sda_out = 1'b1;
        ow.sda_drive = 1'b1;
        ow.busy_res = 1'b0;
      end
    endcase
    if (!ow.sda_drive) ow.sda_out = 1'b0;
    st_next = s;
  end
endmodule

[rtl/i2c_register_master_top.sv]
// channel | dir | payload
// in_ch   | in  | req_type, dev_addr, reg_addr, byte_count, wr_data, sda_in
// out_ch  | out | scl, sda_out, sda_drive, rd_data, rd_valid, wr_take,
//         |     | busy_res, done_res, nack_error
// One word a cycle while out_ch is ready; taken words leave via the output register.
// Output register with a one-deep skid stage: input ready while the skid is empty.
// Reset (rst, synchronous) returns the sequencer to idle and the registers to defaults.
// An output stall holds the sequencer state once the skid is full; no word is dropped.
module i2c_register_master_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  i2crm_if.sink       in_ch,
  i2crm_if.source     out_ch
);
  import i2crm_pkg::*;

  seq_state_t st, st_next;
  in_word_t iw;
  out_word_t ow, out_reg, skid;
  logic out_v, skid_v;
  logic [15:0] timeout_limit;
  logic wide;
  logic take;

  assign iw = in_word_t'(in_ch.data);
  assign in_ch.ready = !skid_v;
  assign take = in_ch.valid && !skid_v;
  assign out_ch.valid = out_v;
  assign out_ch.data = out_reg;

  i2crm_seq u_seq (.st(st), .iw(iw), .timeout_limit(timeout_limit), .wide(wide),
                   .st_next(st_next), .ow(ow));

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
      wide <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIMEOUT) timeout_limit <= cfg_data;
      else wide <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, default: '0};
      out_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (take) st <= st_next;
      if (!out_v || out_ch.ready) begin
        if (skid_v) begin
          out_reg <= skid;
          out_v <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          out_reg <= ow;
          out_v <= take;
        end
      end else if (take) begin
        skid <= ow;
        skid_v <= 1'b1;
      end
    end
  end
endmodule

[rtl/i2crm_checker.sv]
module i2crm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input i2crm_pkg::out_word_t ow
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ow)) else $error("out held");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid) else $error("input stalled with no output word");
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && ow.nack_error |-> ow.done_res) else $error("error without done");
  a_rel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ow.sda_drive |-> !ow.sda_out) else $error("released sda high");
  a_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ow.wr_take || ow.rd_valid) |-> ow.busy_res && ow.sda_drive != ow.rd_valid)
    else $error("take/read mix");
endmodule

bind i2c_register_master_top i2crm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .ow(i2crm_pkg::out_word_t'(out_ch.data))
);

[test/tb_i2c_register_master_top.sv]
`timescale 1ns / 1ps

module tb_i2c_register_master_top;
  import i2crm_pkg::*;

  localparam int IN_W  = $bits(in_word_t);
  localparam int OUT_W = $bits(out_word_t);
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int N_ITEMS = 1050;

  // sequencer phases, numbered locally for the predictor
  typedef enum logic [3:0] {
    S_IDLE, S_START1, S_DEV, S_DEV_ACK, S_RHI, S_RHI_ACK, S_RLO, S_RLO_ACK,
    S_DATA, S_DATA_ACK, S_STOP_MID, S_START2, S_DEVR, S_DEVR_ACK, S_READ, S_STOP
  } seq_phase_e;

  class i2c_scoreboard;
    logic [15:0] timeout_lim;
    logic        wide_addr;
    seq_phase_e  phase;
    logic [1:0]  step;
    logic [2:0]  bits;
    logic [7:0]  shifter;
    logic [7:0]  left;
    logic [15:0] waits;
    logic [7:0]  dev;
    logic [15:0] regad;
    logic [1:0]  kind;
    logic        err;
    out_word_t   pending[$];
    int          fails;

    function new();
      timeout_lim = TIMEOUT_RESET;
      wide_addr = 1'b0;
      phase = S_IDLE;
      step = 0; bits = 0; waits = 0;
      shifter = 0; left = 0; dev = 0; regad = 0; kind = 0; err = 0;
      fails = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_TIMEOUT) timeout_lim = val;
      else wide_addr = val[0];
    endfunction

    function void go(seq_phase_e p);
      phase = p; step = 0; bits = 0; waits = 0;
    endfunction

    function void data_or_stop();
      go(left != 0 ? S_DATA : S_STOP);
    endfunction

    function void ack_done();
      case (phase)
        S_DEV_ACK: begin
          if (kind == REQ_WRITE) data_or_stop();
          else go(wide_addr ? S_RHI : S_RLO);
        end
        S_RHI_ACK: go(S_RLO);
        S_RLO_ACK: begin
          if (kind == REQ_REG_RD) go(S_STOP_MID);
          else data_or_stop();
        end
        S_DATA_ACK: begin
          left = left - 8'd1;
          data_or_stop();
        end
        default: go(left != 0 ? S_READ : S_STOP);
      endcase
    endfunction

    function void note_word(in_word_t w);
      out_word_t o;
      logic [1:0] s;
      o = '0;
      if (phase == S_IDLE && w.req_type != REQ_NONE) begin
        kind = w.req_type; dev = w.dev_addr; regad = w.reg_addr;
        left = w.byte_count; err = 0;
        go(S_START1);
      end
      o.busy_res = 1;
      case (phase)
        S_START1, S_START2: begin
          o.scl = (step != 3);
          o.sda_out = (step < 2);
          o.sda_drive = 1;
          if (step >= 3) go(phase == S_START1 ? S_DEV : S_DEVR);
          else step++;
        end
        S_DEV, S_RHI, S_RLO, S_DATA, S_DEVR: begin
          o.sda_drive = 1;
          if (step == 3) begin
            o.sda_out = 1;
            if (bits >= 1) go(seq_phase_e'(phase + 1));
            else bits++;
          end else begin
            if (step == 0 && bits == 0) begin
              case (phase)
                S_DEV:  shifter = dev;
                S_DEVR: shifter = dev + 8'd1;
                S_RHI:  shifter = regad[15:8];
                S_RLO:  shifter = regad[7:0];
                default: begin
                  shifter = w.wr_data;
                  o.wr_take = 1;
                end
              endcase
            end
            o.scl = (step == 1);
            o.sda_out = shifter[7 - bits];
            if (step == 2) begin
              step = 0;
              if (bits >= 7) begin
                step = 3; bits = 0;
              end else bits++;
            end else step++;
          end
        end
        S_DEV_ACK, S_RHI_ACK, S_RLO_ACK, S_DATA_ACK, S_DEVR_ACK: begin
          if (step == 0) step = 1;
          else begin
            o.scl = 1;
            if (step == 1) step = 2;
            else if (w.sda_in == 0) ack_done();
            else if (waits >= timeout_lim) begin
              err = 1;
              go(S_STOP);
            end else waits++;
          end
        end
        S_READ: begin
          if (step == 3) begin
            o.sda_drive = 1;
            o.sda_out = (left <= 1);
            o.scl = (bits == 1);
            if (bits >= 2) begin
              left = left - 8'd1;
              go(left != 0 ? S_READ : S_STOP);
            end else bits++;
          end else if (step == 0) step = 1;
          else begin
            o.scl = 1;
            shifter = {shifter[6:0], w.sda_in};
            if (bits >= 7) begin
              o.rd_data = shifter; o.rd_valid = 1;
              step = 3; bits = 0;
            end else begin
              bits++; step = 0;
            end
          end
        end
        S_STOP_MID, S_STOP: begin
          s = (step > 2) ? 2'd2 : step;
          o.scl = (s != 0);
          o.sda_out = (s == 2);
          o.sda_drive = 1;
          if (s == 2) begin
            if (phase == S_STOP) begin
              o.done_res = 1; o.nack_error = err;
              go(S_IDLE);
            end else go(S_START2);
          end else step++;
        end
        default: begin
          go(S_IDLE);
          o.scl = 1; o.sda_out = 1; o.sda_drive = 1; o.busy_res = 0;
        end
      endcase
      pending.push_back(o);
    endfunction

    function void check_word(out_word_t a);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", a);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (a.scl !== e.scl) begin
        $error("scl exp %0d got %0d", e.scl, a.scl); fails++;
      end
      if (a.sda_out !== e.sda_out) begin
        $error("sda_out exp %0d got %0d", e.sda_out, a.sda_out); fails++;
      end
      if (a.sda_drive !== e.sda_drive) begin
        $error("sda_drive exp %0d got %0d", e.sda_drive, a.sda_drive); fails++;
      end
      if (a.rd_data !== e.rd_data) begin
        $error("rd_data exp %h got %h", e.rd_data, a.rd_data); fails++;
      end
      if (a.rd_valid !== e.rd_valid) begin
        $error("rd_valid exp %0d got %0d", e.rd_valid, a.rd_valid); fails++;
      end
      if (a.wr_take !== e.wr_take) begin
        $error("wr_take exp %0d got %0d", e.wr_take, a.wr_take); fails++;
      end
      if (a.busy_res !== e.busy_res) begin
        $error("busy_res exp %0d got %0d", e.busy_res, a.busy_res); fails++;
      end
      if (a.done_res !== e.done_res) begin
        $error("done_res exp %0d got %0d", e.done_res, a.done_res); fails++;
      end
      if (a.nack_error !== e.nack_error) begin
        $error("nack_error exp %0d got %0d", e.nack_error, a.nack_error); fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = 0;
  longint      cycles = 0;
  bit          out_stall_on = 1;
  int          stall_left = 0;
  int          n_sent = 0;

  i2crm_if #(.W(IN_W))  in_ch (clk);
  i2crm_if #(.W(OUT_W)) out_ch (clk);

  i2c_scoreboard sb = new();

  i2c_register_master_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_i2c_register_master_top failed");
      $finish;
    end
  end

  // sink side: random stalls, mostly short, now and then a long one
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_word(out_word_t'(out_ch.data));
    if (rst) out_ch.ready <= 0;
    else if (!out_stall_on) out_ch.ready <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else if ($urandom_range(0, 199) == 0) begin
      stall_left <= $urandom_range(10, 40);
      out_ch.ready <= 0;
    end
    else if ($urandom_range(0, 99) < 3) out_ch.ready <= 0;
    else if (!out_ch.ready) out_ch.ready <= ($urandom_range(0, 99) < 40);
    else out_ch.ready <= ($urandom_range(0, 99) >= 15);
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic in_word_t rand_word(logic [1:0] req, logic [7:0] cnt);
    in_word_t w;
    w.req_type = req;
    w.dev_addr = 8'($urandom);
    w.reg_addr = 16'($urandom);
    w.byte_count = cnt;
    w.wr_data = 8'($urandom);
    w.sda_in = 1'($urandom);
    return w;
  endfunction

  // one transaction, ticks until done (at most 3000 more words); ack low with chance ack_pct
  task automatic run_xfer(logic [1:0] req, logic [7:0] cnt, int ack_pct);
    in_word_t w;
    int n;
    w = rand_word(req, cnt);
    send_word(w);
    n = 0;
    while (sb.phase != S_IDLE && n < 3000) begin
      w = rand_word(REQ_NONE, 8'd0);
      if ($urandom_range(0, 19) == 0) w.req_type = 2'($urandom);
      if (sb.phase inside {S_DEV_ACK, S_RHI_ACK, S_RLO_ACK, S_DATA_ACK, S_DEVR_ACK})
        w.sda_in = ($urandom_range(0, 99) >= ack_pct);
      send_word(w);
      n++;
    end
  endtask

  initial begin
    in_word_t w;
    int next_cfg;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: each request type, both widths, zero, one, two and four bytes, timeout
    write_cfg(CFG_TIMEOUT, 16'd0);
    write_cfg(CFG_WIDE, 16'd1);
    w = rand_word(REQ_NONE, 8'd0);
    w.dev_addr = 8'hFF; w.reg_addr = 16'hFFFF; w.wr_data = 8'hFF;
    send_word(w);
    run_xfer(REQ_REG_RD, 8'd0, 100);
    run_xfer(REQ_REG_RD, 8'd1, 100);
    run_xfer(REQ_WRITE, 8'd1, 0);
    out_stall_on = 0;
    run_xfer(REQ_REG_WR, 8'd2, 100);
    out_stall_on = 1;
    drain();
    write_cfg(CFG_TIMEOUT, 16'hFFFF);
    write_cfg(CFG_WIDE, 16'd0);
    run_xfer(REQ_WRITE, 8'd0, 90);
    drain();
    write_cfg(CFG_TIMEOUT, 16'd3);
    run_xfer(REQ_REG_RD, 8'd4, 100);

    next_cfg = 0;
    while (n_sent < N_ITEMS) begin
      if (n_sent >= next_cfg) begin
        drain();
        write_cfg(CFG_TIMEOUT, 16'($urandom_range(0, 6)));
        write_cfg(CFG_WIDE, 16'($urandom_range(0, 1)));
        next_cfg = n_sent + 300;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word(rand_word(2'($urandom), 8'($urandom_range(0, 3))));
      end else begin
        run_xfer(2'($urandom_range(1, 3)), 8'($urandom_range(0, 3)), 80);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) $display("tb_i2c_register_master_top passed");
    else $display("tb_i2c_register_master_top failed");
    $finish;
  end
endmodule
